// ----- rtl/sliding_window_min_max_defines.svh -----
// ----------------------------------------------------------------------------
// Sliding window min/max: assertion macros
// Shared property wrappers for the checks in the RTL modules.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWMM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("swmm check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define SWMM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("swmm check failed one cycle later");

`endif

// ----- rtl/swmm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sliding window min/max package
// Sizes, command and status types and helpers shared by the block.
// ----------------------------------------------------------------------------
package swmm_pkg;

   // Store depth and sample width.
   localparam int WINDOW_MAX = 16;
   localparam int DATA_WIDTH = 16;

   // Derived widths.
   localparam int PTR_W = $clog2(WINDOW_MAX);
   localparam int CNT_W = $clog2(WINDOW_MAX);
   localparam int LEN_W = $clog2(WINDOW_MAX + 1);
   localparam int CFG_W = 5;
   localparam int IDX_W = 16;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // Accept a beat: store sample, update counters.
      logic issue;    // Read the next older window entry.
      logic cmp;      // Fold the read data into min and max.
      logic publish;  // Move the result into the output register.
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic             produce;  // The beat being accepted makes a result.
      logic [LEN_W-1:0] len;      // Effective window length.
   } dp_status_type;

   // Clamp the programmed length into 1..WINDOW_MAX.
   function automatic logic [LEN_W-1:0] effective_len(input logic [CFG_W-1:0] cfg);
      logic [31:0] v;
      v = 32'(cfg);
      if (v == 32'd0) begin
         v = 32'd1;
      end else if (v > 32'(WINDOW_MAX)) begin
         v = 32'(WINDOW_MAX);
      end
      return v[LEN_W-1:0];
   endfunction

   // Step a store pointer back by one, wrapping at the store depth.
   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(WINDOW_MAX - 1) : p - PTR_W'(1);
   endfunction

   // Step a store pointer forward by one, wrapping at the store depth.
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(WINDOW_MAX - 1)) ? '0 : p + PTR_W'(1);
   endfunction

endpackage

// ----- rtl/swmm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/swmm_dp.sv -----
// ----------------------------------------------------------------------------
// Sliding window min/max datapath
// Window store, sequence counters, comparator pair and output register.
// ----------------------------------------------------------------------------
module swmm_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [swmm_pkg::CFG_W-1:0]             csr_wr_data,
   input  logic signed [swmm_pkg::DATA_WIDTH-1:0] req_sample,
   input  logic                                   req_last_sample,
   input  swmm_pkg::ctrl_cmd_type                 cmd,
   output swmm_pkg::dp_status_type                status,
   output logic signed [swmm_pkg::DATA_WIDTH-1:0] rsp_window_min,
   output logic signed [swmm_pkg::DATA_WIDTH-1:0] rsp_window_max,
   output logic [swmm_pkg::IDX_W-1:0]             rsp_window_index,
   output logic                                   rsp_last_window
);

   import swmm_pkg::*;

   logic [CFG_W-1:0]             cfg_len_ff;
   logic [LEN_W-1:0]             fill_ff, fill_in, fill_sat;
   logic [PTR_W-1:0]             wr_ptr_ff;
   logic [PTR_W-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0]             win_cnt_ff, win_cnt_in;
   logic [IDX_W-1:0]             idx_ff;
   logic                         last_ff;
   logic signed [DATA_WIDTH-1:0] min_ff, min_in, max_ff, max_in;
   logic signed [DATA_WIDTH-1:0] rd_data;
   logic [LEN_W-1:0]             len;
   logic                         produce;

   // Length register, written from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_len_ff <= CFG_W'(4);
      end else if (csr_wr_en) begin
         cfg_len_ff <= csr_wr_data;
      end
   end

   assign len = effective_len(cfg_len_ff);

   // Fill count after this beat, saturating at the store depth.
   assign fill_sat = (fill_ff == LEN_W'(WINDOW_MAX)) ? fill_ff : fill_ff + LEN_W'(1);
   assign produce  = (fill_sat >= len);
   assign fill_in  = req_last_sample ? '0 : fill_sat;

   // Window number: advance on a result, clear at the end of a sequence.
   always_comb begin
      win_cnt_in = win_cnt_ff;
      if (req_last_sample) begin
         win_cnt_in = '0;
      end else if (produce) begin
         win_cnt_in = win_cnt_ff + IDX_W'(1);
      end
   end

   assign status.produce = produce;
   assign status.len     = len;

   // Sequence counters and write pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         wr_ptr_ff  <= '0;
         win_cnt_ff <= '0;
      end else if (cmd.load) begin
         fill_ff    <= fill_in;
         wr_ptr_ff  <= ptr_inc(wr_ptr_ff);
         win_cnt_ff <= win_cnt_in;
      end
   end

   // Window store: written on accept, scanned backward one entry a cycle.
   swmm_ram #(
      .WIDTH(DATA_WIDTH),
      .DEPTH(WINDOW_MAX)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.load),
      .wr_addr(wr_ptr_ff),
      .wr_data(req_sample),
      .rd_en  (cmd.issue),
      .rd_addr(rd_ptr_ff),
      .rd_data(rd_data)
   );

   // Scan pointer starts one slot below the entry just written.
   assign rd_ptr_in = cmd.load ? ptr_dec(wr_ptr_ff) : ptr_dec(rd_ptr_ff);

   // Comparator pair folds each read entry into the running extremes.
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (cmd.load) begin
         min_in = req_sample;
         max_in = req_sample;
      end else if (cmd.cmp) begin
         if (rd_data < min_ff) begin
            min_in = rd_data;
         end
         if (rd_data > max_ff) begin
            max_in = rd_data;
         end
      end
   end

   // Scan registers and the per-item tags.
   always_ff @(posedge clock) begin
      if (cmd.load || cmd.issue) begin
         rd_ptr_ff <= rd_ptr_in;
      end
      min_ff <= min_in;
      max_ff <= max_in;
      if (cmd.load) begin
         idx_ff  <= win_cnt_ff;
         last_ff <= req_last_sample;
      end
   end

   // Output register, loaded when the result is handed over.
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_window_min   <= min_ff;
         rsp_window_max   <= max_ff;
         rsp_window_index <= idx_ff;
         rsp_last_window  <= last_ff;
      end
   end

endmodule

// ----- rtl/swmm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sliding window min/max controller
// Sequences accept, store scan and result hand-over for one item at a time.
// ----------------------------------------------------------------------------
`include "sliding_window_min_max_defines.svh"

module swmm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  swmm_pkg::dp_status_type status,
   output swmm_pkg::ctrl_cmd_type  cmd
);

   import swmm_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      pend_in     = 1'b0;
      cmd.load    = 1'b0;
      cmd.issue   = 1'b0;
      cmd.cmp     = 1'b0;
      cmd.publish = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               cnt_in   = CNT_W'(status.len - LEN_W'(1));
               if (status.produce) begin
                  state_in = (status.len == LEN_W'(1)) ? S_DONE : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Issue reads while entries remain; compare in the following cycle.
            cmd.cmp = pend_ff;
            if (cnt_ff != '0) begin
               cmd.issue = 1'b1;
               pend_in   = 1'b1;
               cnt_in    = cnt_ff - CNT_W'(1);
            end else if (pend_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output valid: set on hand-over, cleared when the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Every compare consumes a read issued in the previous cycle.
   `SWMM_ASSERT_SAME(a_cmp_follows_issue, cmd.cmp, $past(cmd.issue))
   // A handed-over result is visible on the output in the next cycle.
   `SWMM_ASSERT_NEXT(a_publish_sets_valid, cmd.publish, rsp_valid)
   // A beat that makes no result leaves the block ready at once.
   `SWMM_ASSERT_NEXT(a_no_result_idle, accept && !status.produce, req_ready)
   // A length-one window skips the scan.
   `SWMM_ASSERT_NEXT(a_len_one_done, accept && status.produce && status.len == LEN_W'(1),
                     state_ff == S_DONE)

endmodule

// ----- rtl/sliding_window_min_max.sv -----
// ----------------------------------------------------------------------------
// Sliding window min/max
// Minimum and maximum over the last window_length samples of a sequence.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the req_ channel (valid/ready), one beat per sample, with
// req_last_sample marking the final sample of a sequence. Each sample from the
// window_length-th one of a sequence onward yields one rsp_ beat with
// the window minimum, maximum, window number and a last-window flag. Shorter
// sequences yield nothing but still clear the fill count and window number.
// The window length is written through csr_wr_en/csr_wr_data by the user,
// only while idle, as the block does not enforce it; zero acts as 1 and
// values above 16 act as 16. A beat that makes no result leaves the block
// idle and ready for the next sample. For a result over a window of L samples,
// L of two or more, the store's single read port scans the L - 1 older entries
// one a cycle, each read registered and compared in the cycle after it; the
// result then passes through a done state into the output register. A window
// of one sample skips the scan and goes straight to the done state.
// A finished result sits in the output register, so the next sample is
// accepted while it waits; if the receiver stalls, the following result
// holds in the block and req_ready stays low until the register frees.
// Reset clears the counters, the output valid and sets the length to 4.
// ----------------------------------------------------------------------------
module sliding_window_min_max (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [swmm_pkg::CFG_W-1:0]             csr_wr_data,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [swmm_pkg::DATA_WIDTH-1:0] req_sample,
   input  logic                                   req_last_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [swmm_pkg::DATA_WIDTH-1:0] rsp_window_min,
   output logic signed [swmm_pkg::DATA_WIDTH-1:0] rsp_window_max,
   output logic [swmm_pkg::IDX_W-1:0]             rsp_window_index,
   output logic                                   rsp_last_window
);

   import swmm_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Controller.
   swmm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   // Datapath.
   swmm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .cmd             (cmd),
      .status          (status),
      .rsp_window_min  (rsp_window_min),
      .rsp_window_max  (rsp_window_max),
      .rsp_window_index(rsp_window_index),
      .rsp_last_window (rsp_last_window)
   );

endmodule
